@@ rtl/core/stbg_pkg.sv @@
package stbg_pkg;

	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W   = 5;

	// limit gain times 8192 times 2^16
	localparam logic signed [31:0] X_START    = 32'sd326016437;
	// 2^48 / 44100
	localparam logic        [39:0] STEP_RESET = 40'd6382652533;

	localparam logic signed [16:0] SAMPLE_HI = 17'sd8192;
	localparam logic signed [16:0] SAMPLE_LO = -17'sd8192;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_LOAD,
		ST_ROT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                  take;      // input item accepted
		logic                  calc_inc;  // form phase increment
		logic                  init_rot;  // fold phase, start rotation
		logic                  rot;       // one rotation step
		logic [ATAN_IDX_W-1:0] step_idx;
		logic                  emit;      // write sample, advance phase
		logic                  last;
	} cmd_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [29:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/sine_tone_burst_generator_unit.sv @@
// sine tone burst generator: each input item (tone_freq in hertz, sample_count) produces a
// burst of sample_count sine samples, sin(phase) * 0.25 in signed q1.15 (range -8192..8192),
// tlast set on the final one. a 32-bit phase accumulator (2^32 = one turn) starts at zero
// after reset and runs on across bursts; after each sample it advances by
// (tone_freq * phase_step_per_hz) >> 16, wrapping modulo one turn. phase_step_per_hz is
// 2^48 divided by the output rate in hertz, reset value set for 44100 Hz; write it through
// cfg_we / cfg_wdata only while the block is idle. a sample_count of zero produces nothing,
// counts above MAX_BURST are cut to MAX_BURST. sequence: an item first has its increment
// formed (multiply on acceptance, then sum), then each sample goes through fold, CORDIC_STEPS
// rotation steps and write out, paced by the one CORDIC stage that iterates a step per cycle;
// a stalled output holds the burst at the write out. a new item is taken once the previous
// burst's last sample sits in the output register.
module sine_tone_burst_generator_unit #(
	parameter int MAX_BURST    = 64,   // 1..64
	parameter int CORDIC_STEPS = 16    // 8..24
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [15:0] tone_freq, [22:16] sample_count, [23] zero
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [14:0] sample, [15] zero
	output logic        m_axis_tlast,
	// phase_step_per_hz register
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata
);

	stbg_pkg::cmd_t    cmd;
	logic              out_free;
	logic signed [14:0] sample;

	// sequencer: burst count, rotation step count
	stbg_ctrl #(
		.MAX_BURST   (MAX_BURST),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.sample_count(s_axis_tdata[22:16]),
		.out_free    (out_free),
		.cmd         (cmd)
	);

	// increment multiply, phase accumulator, cordic, output register
	stbg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tone_freq (s_axis_tdata[15:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sample(sample),
		.out_last  (m_axis_tlast)
	);

	// sample in the low bits, padded to two whole bytes
	assign m_axis_tdata = {1'b0, sample};

endmodule

@@ rtl/core/stbg_ctrl.sv @@
module stbg_ctrl #(
	parameter int MAX_BURST    = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [6:0]           sample_count,
	input  logic                 out_free,
	output stbg_pkg::cmd_t       cmd
);

	localparam int CW = $clog2(MAX_BURST + 1);
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	stbg_pkg::state_t state_q, state_d;
	logic [CW-1:0]    remain_q, remain_d;
	logic [SW-1:0]    step_q, step_d;
	logic [CW-1:0]    count_clamped;
	logic             accept;
	logic             last_step;

	assign count_clamped = (sample_count > 7'(MAX_BURST)) ? CW'(MAX_BURST)
	                                                       : CW'(sample_count);
	assign accept    = in_valid && in_ready;
	assign last_step = (step_q == SW'(CORDIC_STEPS - 1));

	// next state
	always_comb begin
		state_d  = state_q;
		remain_d = remain_q;
		step_d   = step_q;
		unique case (state_q)
			stbg_pkg::ST_IDLE: begin
				if (in_valid && count_clamped != '0) begin
					remain_d = count_clamped;
					state_d  = stbg_pkg::ST_INC;
				end
			end
			stbg_pkg::ST_INC: begin
				state_d = stbg_pkg::ST_LOAD;
			end
			stbg_pkg::ST_LOAD: begin
				step_d  = '0;
				state_d = stbg_pkg::ST_ROT;
			end
			stbg_pkg::ST_ROT: begin
				step_d = step_q + SW'(1);
				if (last_step) begin
					state_d = stbg_pkg::ST_EMIT;
				end
			end
			stbg_pkg::ST_EMIT: begin
				if (out_free) begin
					remain_d = remain_q - CW'(1);
					state_d  = (remain_q == CW'(1)) ? stbg_pkg::ST_IDLE : stbg_pkg::ST_LOAD;
				end
			end
			default: state_d = stbg_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == stbg_pkg::ST_IDLE);
		cmd          = '0;
		cmd.take     = accept;
		cmd.step_idx = stbg_pkg::ATAN_IDX_W'(step_q);
		unique case (state_q)
			stbg_pkg::ST_IDLE: ;
			stbg_pkg::ST_INC:  cmd.calc_inc = 1'b1;
			stbg_pkg::ST_LOAD: cmd.init_rot = 1'b1;
			stbg_pkg::ST_ROT:  cmd.rot = 1'b1;
			stbg_pkg::ST_EMIT: begin
				cmd.emit = out_free;
				cmd.last = (remain_q == CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stbg_pkg::ST_IDLE;
			remain_q <= '0;
			step_q   <= '0;
		end else begin
			state_q  <= state_d;
			remain_q <= remain_d;
			step_q   <= step_d;
		end
	end

	// a burst in progress always has samples left
	a_remain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != stbg_pkg::ST_IDLE |-> remain_q != '0)
		else $error("burst running with no samples left");

	// an empty burst leaves the controller idle
	a_empty_burst: assert property (@(posedge clk) disable iff (!arst_n)
		accept && count_clamped == '0 |=> state_q == stbg_pkg::ST_IDLE)
		else $error("empty burst started work");

endmodule

@@ rtl/core/stbg_dp.sv @@
module stbg_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stbg_pkg::cmd_t        cmd,
	input  logic [15:0]           tone_freq,
	input  logic                  cfg_we,
	input  logic [39:0]           cfg_wdata,
	output logic                  out_free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [14:0]    out_sample,
	output logic                  out_last
);

	logic        [39:0] step_cfg_q;
	logic        [47:0] prod_lo_q;
	logic        [23:0] prod_hi_q;
	logic        [31:0] inc_q;
	logic        [31:0] phase_q;
	logic signed [31:0] x_q, y_q;
	logic signed [32:0] z_q;

	logic        [1:0]  quad;
	logic        [31:0] folded;
	logic signed [31:0] dx, dy;
	logic signed [32:0] atan_v;
	logic signed [32:0] y_rnd;
	logic signed [16:0] r_full;
	logic signed [16:0] r_clamped;

	assign quad   = phase_q[31:30];
	assign folded = (quad == 2'd1 || quad == 2'd2) ? (32'h8000_0000 - phase_q) : phase_q;
	assign dx     = y_q >>> cmd.step_idx;
	assign dy     = x_q >>> cmd.step_idx;
	assign atan_v = signed'({3'b000, stbg_pkg::atan_turn(cmd.step_idx)});

	// round to nearest, ties up, then clamp
	assign y_rnd  = {y_q[31], y_q} + 33'sd32768;
	assign r_full = 17'(y_rnd >>> 16);
	always_comb begin
		priority if (r_full > stbg_pkg::SAMPLE_HI) begin
			r_clamped = stbg_pkg::SAMPLE_HI;
		end else if (r_full < stbg_pkg::SAMPLE_LO) begin
			r_clamped = stbg_pkg::SAMPLE_LO;
		end else begin
			r_clamped = r_full;
		end
	end

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cfg_q <= stbg_pkg::STEP_RESET;
			phase_q    <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_cfg_q <= cfg_wdata;
			end
			if (cmd.emit) begin
				phase_q <= phase_q + inc_q;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_lo_q <= tone_freq * step_cfg_q[31:0];
			prod_hi_q <= tone_freq * step_cfg_q[39:32];
		end
		if (cmd.calc_inc) begin
			inc_q <= prod_lo_q[47:16] + {prod_hi_q[15:0], 16'h0000};
		end
		if (cmd.init_rot) begin
			x_q <= stbg_pkg::X_START;
			y_q <= '0;
			z_q <= {folded[31], folded};
		end else if (cmd.rot) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
		if (cmd.emit) begin
			out_sample <= r_clamped[14:0];
			out_last   <= cmd.last;
		end
	end

	// phase moves only when a sample is written out
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.emit |=> $stable(phase_q))
		else $error("phase changed without a sample");

	// a written sample is presented next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted sample not presented");

endmodule
